// ===== sv/trd_pkg.sv =====
// trd_pkg: shared types and constants of the touch report deframer
// framing bytes, command codes, event and register codes, pipeline records
// no dependencies
package trd_pkg;

	// framing
	localparam logic [7:0] ESC_BYTE   = 8'h2A;
	localparam logic [7:0] LIT_BYTE   = 8'h40;
	localparam logic [7:0] CHECK_FLAG = 8'h80;
	localparam logic [7:0] PHASE_MASK = 8'hF0;
	localparam logic [7:0] CMD_POINT  = 8'h70;	// 'p'
	localparam logic [7:0] CMD_STATUS = 8'h74;	// 't'

	localparam int HEAD_DEPTH = 5;
	localparam int POINT_LEN  = 5;
	localparam int STATUS_LEN = 2;

	// arithmetic widths
	localparam int COEF_W    = 16;
	localparam int SIZE_W    = 13;
	localparam int RAW_W     = 16;
	localparam int MUL_OP_W  = COEF_W + 1;
	localparam int MUL_W     = 2 * MUL_OP_W;
	localparam int PROD_W    = 33;
	localparam int ACC_W     = 35;
	localparam int FRAC_BITS = 12;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);

	// register reset values
	localparam logic signed [COEF_W-1:0] RST_COEF_XX = 16'sd4719;
	localparam logic signed [COEF_W-1:0] RST_COEF_XY = -16'sd594;
	localparam logic signed [COEF_W-1:0] RST_COEF_YX = -16'sd180;
	localparam logic signed [COEF_W-1:0] RST_COEF_YY = 16'sd4555;
	localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd800;
	localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd480;

	typedef enum logic [2:0] {
		CFG_COEF_XX = 3'd0,
		CFG_COEF_XY = 3'd1,
		CFG_COEF_YX = 3'd2,
		CFG_COEF_YY = 3'd3,
		CFG_WIDTH   = 3'd4,
		CFG_HEIGHT  = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_OTHER  = 3'd0,
		EV_START  = 3'd1,
		EV_MOVE   = 3'd2,
		EV_UP     = 3'd3,
		EV_STATUS = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		FR_OTHER  = 2'd0,
		FR_POINT  = 2'd1,
		FR_STATUS = 2'd2
	} frame_cls_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] xx;
		logic signed [COEF_W-1:0] xy;
		logic signed [COEF_W-1:0] yx;
		logic signed [COEF_W-1:0] yy;
	} coef_set_t;

	// one checksum-valid frame as it leaves the deframer
	typedef struct packed {
		frame_cls_t       cls;
		logic             phase_zero;
		logic             release_touch;
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} frame_rec_t;

	// the same frame with its calibration products
	typedef struct packed {
		frame_cls_t               cls;
		logic                     phase_zero;
		logic                     release_touch;
		logic signed [PROD_W-1:0] p_xx;
		logic signed [PROD_W-1:0] p_xy;
		logic signed [PROD_W-1:0] p_yx;
		logic signed [PROD_W-1:0] p_yy;
	} calib_t;

endpackage

// ===== sv/touch_report_deframer.sv =====
// touch_report_deframer: the result of the closing checksum byte passes through the stage-one record,
// the product register and the output register;
// throughput is one byte per cycle while in_stall is low, bytes that close nothing produce no result
// input stalls only when the stage-one record cannot move on
// asynchronous active-low reset clears frame state, pen state, counters and registers;
// the head byte store holds no reset value and needs no clearing pass
module touch_report_deframer #(
	parameter int PAYLOAD_CAPACITY = 512,
	parameter int COORD_BITS       = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// byte stream in
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	// result out
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            event_kind,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic [COORD_BITS-1:0] from_x,
	output logic [COORD_BITS-1:0] from_y,
	output logic                  pen_down_now,
	output logic [31:0]           frames_total,
	output logic [31:0]           events_total,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	trd_pkg::coef_set_t             coefs_q;
	logic [trd_pkg::SIZE_W-1:0]     width_q, height_q;

	logic                           rec_valid_s1, rec_stall;
	trd_pkg::frame_rec_t            rec_s1;
	logic                           calib_valid_s2, calib_stall;
	trd_pkg::calib_t                calib_s2;

	// register file, always ready, writes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.xx <= trd_pkg::RST_COEF_XX;
			coefs_q.xy <= trd_pkg::RST_COEF_XY;
			coefs_q.yx <= trd_pkg::RST_COEF_YX;
			coefs_q.yy <= trd_pkg::RST_COEF_YY;
			width_q    <= trd_pkg::RST_WIDTH;
			height_q   <= trd_pkg::RST_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				trd_pkg::CFG_COEF_XX: coefs_q.xx <= cfg_data;
				trd_pkg::CFG_COEF_XY: coefs_q.xy <= cfg_data;
				trd_pkg::CFG_COEF_YX: coefs_q.yx <= cfg_data;
				trd_pkg::CFG_COEF_YY: coefs_q.yy <= cfg_data;
				trd_pkg::CFG_WIDTH:   width_q    <= cfg_data[trd_pkg::SIZE_W-1:0];
				trd_pkg::CFG_HEIGHT:  height_q   <= cfg_data[trd_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// byte parser, one transfer per cycle unless in_stall is high, record per good frame
	trd_deframer #(
		.PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
	) u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.rec_valid_s1(rec_valid_s1),
		.rec_s1      (rec_s1),
		.rec_stall   (rec_stall)
	);

	// calibration products
	trd_calib u_calib (
		.clk           (clk),
		.arst_n        (arst_n),
		.coefs         (coefs_q),
		.rec_valid_s1  (rec_valid_s1),
		.rec_s1        (rec_s1),
		.rec_stall     (rec_stall),
		.calib_valid_s2(calib_valid_s2),
		.calib_s2      (calib_s2),
		.calib_stall   (calib_stall)
	);

	// round, clamp, pen tracking and result register
	trd_event #(
		.COORD_BITS(COORD_BITS)
	) u_event (
		.clk           (clk),
		.arst_n        (arst_n),
		.screen_width  (width_q),
		.screen_height (height_q),
		.calib_valid_s2(calib_valid_s2),
		.calib_s2      (calib_s2),
		.calib_stall   (calib_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.point_x       (point_x),
		.point_y       (point_y),
		.from_x        (from_x),
		.from_y        (from_y),
		.pen_down_now  (pen_down_now),
		.frames_total  (frames_total),
		.events_total  (events_total)
	);

endmodule

// ===== sv/trd_deframer.sv =====
// trd_deframer: byte-level frame parser with escape handling and checksum check
// emits one frame record per checksum-valid frame into a stage-one register
// depends on trd_pkg
module trd_deframer #(
	parameter int PAYLOAD_CAPACITY = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	output logic                rec_valid_s1,
	output trd_pkg::frame_rec_t rec_s1,
	input  logic                rec_stall
);

	localparam int CW = $clog2(PAYLOAD_CAPACITY + 1);

	logic          in_frame_q, after_escape_q, have_command_q;
	logic [7:0]    command_q, sum_q;
	logic [CW-1:0] count_q;
	logic [7:0]    head_q [trd_pkg::HEAD_DEPTH];

	logic          nx_in_frame, nx_after_escape, nx_have_command;
	logic [7:0]    nx_command, nx_sum;
	logic [CW-1:0] nx_count;
	logic          put_one, put_two, close_ok;
	logic [7:0]    one_val, want;
	trd_pkg::frame_rec_t rec;
	logic          in_fire;

	assign in_stall = rec_valid_s1 && rec_stall;
	assign in_fire  = in_valid && !in_stall;
	assign want     = (sum_q ^ 8'(count_q)) | trd_pkg::CHECK_FLAG;

	always_comb begin
		nx_in_frame     = in_frame_q;
		nx_after_escape = after_escape_q;
		nx_have_command = have_command_q;
		nx_command      = command_q;
		nx_sum          = sum_q;
		nx_count        = count_q;
		put_one         = 1'b0;
		put_two         = 1'b0;
		close_ok        = 1'b0;
		one_val         = rx_byte;
		if (!in_frame_q) begin
			if (rx_byte == trd_pkg::ESC_BYTE) begin
				nx_in_frame     = 1'b1;
				nx_after_escape = 1'b1;
				nx_have_command = 1'b0;
				nx_command      = '0;
				nx_sum          = '0;
				nx_count        = '0;
			end
		end else if (after_escape_q) begin
			nx_after_escape = 1'b0;
			priority if (rx_byte == trd_pkg::ESC_BYTE) begin
				// restart, still waiting for the byte after an escape
				nx_have_command = 1'b0;
				nx_count        = '0;
				nx_sum          = '0;
				nx_after_escape = 1'b1;
			end else if (rx_byte == trd_pkg::LIT_BYTE) begin
				one_val = trd_pkg::ESC_BYTE;
				put_one = (count_q < CW'(PAYLOAD_CAPACITY));
			end else if (rx_byte[7]) begin
				close_ok        = have_command_q && (rx_byte == want);
				nx_in_frame     = 1'b0;
				nx_have_command = 1'b0;
				nx_command      = '0;
				nx_sum          = '0;
				nx_count        = '0;
			end else if (!have_command_q) begin
				nx_command      = rx_byte;
				nx_have_command = 1'b1;
			end else begin
				put_two = ({1'b0, count_q} + (CW + 1)'(2)) <= (CW + 1)'(PAYLOAD_CAPACITY);
			end
		end else begin
			priority if (rx_byte == trd_pkg::ESC_BYTE) begin
				nx_after_escape = 1'b1;
			end else if (!have_command_q) begin
				nx_command      = rx_byte;
				nx_have_command = 1'b1;
			end else begin
				put_one = (count_q < CW'(PAYLOAD_CAPACITY));
			end
		end
		if (put_one) begin
			nx_sum   = sum_q + one_val;
			nx_count = count_q + CW'(1);
		end
		if (put_two) begin
			nx_sum   = sum_q + trd_pkg::ESC_BYTE + rx_byte;
			nx_count = count_q + CW'(2);
		end
	end

	// classify the frame that the checksum byte closes
	always_comb begin
		rec.phase_zero    = (head_q[0] & trd_pkg::PHASE_MASK) == 8'h00;
		rec.release_touch = (head_q[1] == 8'h00);
		rec.raw_x         = {head_q[2], head_q[1]};
		rec.raw_y         = {head_q[4], head_q[3]};
		priority if (command_q == trd_pkg::CMD_POINT && count_q == CW'(trd_pkg::POINT_LEN))
			rec.cls = trd_pkg::FR_POINT;
		else if (command_q == trd_pkg::CMD_STATUS && count_q == CW'(trd_pkg::STATUS_LEN))
			rec.cls = trd_pkg::FR_STATUS;
		else
			rec.cls = trd_pkg::FR_OTHER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			after_escape_q <= 1'b0;
			have_command_q <= 1'b0;
			command_q      <= '0;
			sum_q          <= '0;
			count_q        <= '0;
			rec_valid_s1   <= 1'b0;
		end else begin
			if (in_fire) begin
				in_frame_q     <= nx_in_frame;
				after_escape_q <= nx_after_escape;
				have_command_q <= nx_have_command;
				command_q      <= nx_command;
				sum_q          <= nx_sum;
				count_q        <= nx_count;
				rec_valid_s1   <= close_ok;
			end else if (!rec_stall) begin
				rec_valid_s1 <= 1'b0;
			end
		end
	end

	// first payload bytes only, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < trd_pkg::HEAD_DEPTH; i++) begin
				if (put_one && count_q == CW'(i))
					head_q[i] <= one_val;
				if (put_two && count_q == CW'(i))
					head_q[i] <= trd_pkg::ESC_BYTE;
				if (put_two && i > 0 && count_q == CW'(i - 1))
					head_q[i] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && close_ok)
			rec_s1 <= rec;
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(PAYLOAD_CAPACITY))
		else $error("payload count beyond capacity");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (!after_escape_q && !have_command_q && count_q == '0))
		else $error("frame state left over outside a frame");

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_s1 && rec_stall |=> rec_valid_s1 && $stable(rec_s1))
		else $error("stage one record lost while stalled");

endmodule

// ===== sv/trd_calib.sv =====
// trd_calib: calibration multiply stage, four signed products per frame record
// registers the products with the frame class into stage two
// depends on trd_pkg
module trd_calib (
	input  logic               clk,
	input  logic               arst_n,
	input  trd_pkg::coef_set_t coefs,
	input  logic               rec_valid_s1,
	input  trd_pkg::frame_rec_t rec_s1,
	output logic               rec_stall,
	output logic               calib_valid_s2,
	output trd_pkg::calib_t    calib_s2,
	input  logic               calib_stall
);

	logic signed [trd_pkg::MUL_OP_W-1:0] c_xx, c_xy, c_yx, c_yy, r_x, r_y;
	logic signed [trd_pkg::MUL_W-1:0]    m_xx, m_xy, m_yx, m_yy;
	logic                                advance;

	assign c_xx = {coefs.xx[trd_pkg::COEF_W-1], coefs.xx};
	assign c_xy = {coefs.xy[trd_pkg::COEF_W-1], coefs.xy};
	assign c_yx = {coefs.yx[trd_pkg::COEF_W-1], coefs.yx};
	assign c_yy = {coefs.yy[trd_pkg::COEF_W-1], coefs.yy};
	assign r_x  = {1'b0, rec_s1.raw_x};
	assign r_y  = {1'b0, rec_s1.raw_y};

	assign m_xx = c_xx * r_x;
	assign m_xy = c_xy * r_y;
	assign m_yx = c_yx * r_x;
	assign m_yy = c_yy * r_y;

	assign rec_stall = calib_valid_s2 && calib_stall;
	assign advance   = !rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			calib_valid_s2 <= 1'b0;
		else if (advance)
			calib_valid_s2 <= rec_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && rec_valid_s1) begin
			calib_s2.cls           <= rec_s1.cls;
			calib_s2.phase_zero    <= rec_s1.phase_zero;
			calib_s2.release_touch <= rec_s1.release_touch;
			calib_s2.p_xx          <= trd_pkg::PROD_W'(m_xx);
			calib_s2.p_xy          <= trd_pkg::PROD_W'(m_xy);
			calib_s2.p_yx          <= trd_pkg::PROD_W'(m_yx);
			calib_s2.p_yy          <= trd_pkg::PROD_W'(m_yy);
		end
	end

endmodule

// ===== sv/trd_event.sv =====
// trd_event: final stage, rounding and clamping, pen tracking, counters
// holds the output register of the result channel
// depends on trd_pkg
module trd_event #(
	parameter int COORD_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [trd_pkg::SIZE_W-1:0]  screen_width,
	input  logic [trd_pkg::SIZE_W-1:0]  screen_height,
	input  logic                        calib_valid_s2,
	input  trd_pkg::calib_t             calib_s2,
	output logic                        calib_stall,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  event_kind,
	output logic [COORD_BITS-1:0]       point_x,
	output logic [COORD_BITS-1:0]       point_y,
	output logic [COORD_BITS-1:0]       from_x,
	output logic [COORD_BITS-1:0]       from_y,
	output logic                        pen_down_now,
	output logic [31:0]                 frames_total,
	output logic [31:0]                 events_total
);

	localparam int AW = trd_pkg::ACC_W;

	function automatic logic [COORD_BITS-1:0] map_axis(
		input logic signed [AW-1:0]        acc,
		input logic [trd_pkg::SIZE_W-1:0]  size
	);
		logic [AW-1:0] v, lim, cmax;
		cmax = AW'(1) << COORD_BITS;
		v    = acc[AW-1] ? '0 : AW'($unsigned(acc) >> trd_pkg::FRAC_BITS);
		lim  = (AW'(size) > cmax) ? cmax : AW'(size);
		if (lim != '0)
			lim = lim - AW'(1);
		return (v > lim) ? lim[COORD_BITS-1:0] : v[COORD_BITS-1:0];
	endfunction

	logic                   pen_q;
	logic [COORD_BITS-1:0]  last_x_q, last_y_q;
	logic [31:0]            frames_q, events_q;

	logic signed [AW-1:0]   acc_x, acc_y;
	logic                   nx_pen, fire;
	logic [31:0]            nx_events;
	logic [COORD_BITS-1:0]  px, py, fx, fy, map_x, map_y;
	trd_pkg::event_kind_t   kind;

	assign calib_stall = out_valid && out_stall;
	assign fire        = calib_valid_s2 && !calib_stall;

	assign acc_x = AW'(calib_s2.p_xx) + AW'(calib_s2.p_xy) + trd_pkg::ROUND_HALF;
	assign acc_y = AW'(calib_s2.p_yx) + AW'(calib_s2.p_yy) + trd_pkg::ROUND_HALF;
	assign map_x = map_axis(acc_x, screen_width);
	assign map_y = map_axis(acc_y, screen_height);

	always_comb begin
		nx_pen    = pen_q;
		nx_events = events_q;
		kind      = trd_pkg::EV_OTHER;
		px        = '0;
		py        = '0;
		fx        = '0;
		fy        = '0;
		unique case (calib_s2.cls)
			trd_pkg::FR_POINT: begin
				nx_events = events_q + 32'd1;
				if (calib_s2.phase_zero) begin
					nx_pen = 1'b0;
					kind   = trd_pkg::EV_UP;
				end else begin
					px = map_x;
					py = map_y;
					if (pen_q) begin
						kind = trd_pkg::EV_MOVE;
						fx   = last_x_q;
						fy   = last_y_q;
					end else begin
						kind = trd_pkg::EV_START;
					end
					nx_pen = 1'b1;
				end
			end
			trd_pkg::FR_STATUS: begin
				if (calib_s2.release_touch)
					nx_pen = 1'b0;
				nx_events = events_q + 32'd1;
				kind      = trd_pkg::EV_STATUS;
			end
			default: begin
				kind = trd_pkg::EV_OTHER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pen_q     <= 1'b0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			frames_q  <= '0;
			events_q  <= '0;
		end else begin
			if (fire) begin
				out_valid <= 1'b1;
				pen_q     <= nx_pen;
				frames_q  <= frames_q + 32'd1;
				events_q  <= nx_events;
				if (kind == trd_pkg::EV_START || kind == trd_pkg::EV_MOVE) begin
					last_x_q <= px;
					last_y_q <= py;
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			event_kind   <= kind;
			point_x      <= px;
			point_y      <= py;
			from_x       <= fx;
			from_y       <= fy;
			pen_down_now <= nx_pen;
			frames_total <= frames_q + 32'd1;
			events_total <= nx_events;
		end
	end

	a_events_with_frames: assert property (@(posedge clk) disable iff (!arst_n)
		(events_q != $past(events_q)) |-> (frames_q != $past(frames_q)))
		else $error("event count moved without a frame");

	a_move_pen_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == trd_pkg::EV_MOVE || event_kind == trd_pkg::EV_START)
		|-> pen_down_now)
		else $error("point event reported with pen up");

	a_frames_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frames_total == frames_q))
		else $error("reported frame count out of step");

endmodule
